[hdl/mchs_pkg.sv]
// ----------------------------------------------------------------------------
// mchs_pkg: shared definitions for the cell hop selector
// Mixing constants, configuration register indexes, move codes and the
// status word that the item queue reports to the top level and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package mchs_pkg;

  localparam int DRAW_BITS_DEF  = 53;
  localparam int FLUX_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [63:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_C1       = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2       = 64'h94d049bb133111eb;
  localparam logic [63:0] TAG_MULT     = 64'hd2b74407b1ce6e93;
  localparam logic [63:0] MOVE_DRAW_ID = 64'd0;
  localparam logic [63:0] DRAW_TERM    = 64'(MOVE_DRAW_ID * MIX_C2);

  typedef enum logic [1:0] {
    CFG_RANDOM_SEED = 2'd0,
    CFG_STEP_CYCLE  = 2'd1,
    CFG_DIMENSIONS  = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    MOVE_NONE    = 3'd0,
    MOVE_X1_DOWN = 3'd1,
    MOVE_X1_UP   = 3'd2,
    MOVE_X2_DOWN = 3'd3,
    MOVE_X2_UP   = 3'd4,
    MOVE_X3_DOWN = 3'd5,
    MOVE_X3_UP   = 3'd6
  } move_code_t;

  typedef struct packed {
    logic empty;
    logic nearly_full;
  } q_status_t;

endpackage

`default_nettype wire

[hdl/monte_carlo_cell_hop_select.sv]
// Path: an accepted particle passes the front-end register, the item queue,
// the back-end pipeline and the output register to the out ports, marked by out_strobe.
// Throughput: one particle per cycle while busy is low; the mixing and scaling
// pipeline takes a new item every cycle and the result side never stalls.
// Reset: synchronous, active low; busy is high during reset, all pipelines
// empty, random_seed and step_cycle clear and dimensions returns to one.
// ----------------------------------------------------------------------------
// monte_carlo_cell_hop_select: tracer particle cell hop selector
// Draws a keyed random fraction per particle and selects the face through
// which the tracer leaves its cell, following the outgoing face fluxes.
// ----------------------------------------------------------------------------
`default_nettype none

module monte_carlo_cell_hop_select
  import mchs_pkg::*;
#(
  parameter int DRAW_BITS  = DRAW_BITS_DEF,
  parameter int FLUX_WIDTH = FLUX_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [63:0]           cfg_data,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [30:0]           in_particle_tag,
  input  wire logic                  in_active,
  input  wire logic [FLUX_WIDTH-1:0] in_cell_mass,
  input  wire logic [FLUX_WIDTH-1:0] in_flux_x1_low,
  input  wire logic [FLUX_WIDTH-1:0] in_flux_x1_high,
  input  wire logic [FLUX_WIDTH-1:0] in_flux_x2_low,
  input  wire logic [FLUX_WIDTH-1:0] in_flux_x2_high,
  input  wire logic [FLUX_WIDTH-1:0] in_flux_x3_low,
  input  wire logic [FLUX_WIDTH-1:0] in_flux_x3_high,
  output logic                       out_strobe,
  output logic [2:0]                 out_move_code
);

  localparam int CUM_WIDTH = FLUX_WIDTH + 3;
  localparam int ENTRY_W   = 64 + FLUX_WIDTH + 6 * CUM_WIDTH + 1;
  localparam int LATENCY   = 9;

  logic               take;
  logic               push;
  logic [ENTRY_W-1:0] push_data;
  logic               pop;
  logic [ENTRY_W-1:0] pop_data;
  q_status_t          q_status;

  assign busy = !rst_n || q_status.nearly_full;
  assign take = start && !busy;

  mchs_front #(
    .FLUX_WIDTH (FLUX_WIDTH),
    .CUM_WIDTH  (CUM_WIDTH),
    .ENTRY_W    (ENTRY_W)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .take            (take),
    .in_particle_tag (in_particle_tag),
    .in_active       (in_active),
    .in_cell_mass    (in_cell_mass),
    .in_flux_x1_low  (in_flux_x1_low),
    .in_flux_x1_high (in_flux_x1_high),
    .in_flux_x2_low  (in_flux_x2_low),
    .in_flux_x2_high (in_flux_x2_high),
    .in_flux_x3_low  (in_flux_x3_low),
    .in_flux_x3_high (in_flux_x3_high),
    .push            (push),
    .push_data       (push_data)
  );

  mchs_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  mchs_back #(
    .DRAW_BITS  (DRAW_BITS),
    .FLUX_WIDTH (FLUX_WIDTH),
    .CUM_WIDTH  (CUM_WIDTH),
    .ENTRY_W    (ENTRY_W)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (!q_status.empty),
    .item_data     (pop_data),
    .item_pop      (pop),
    .out_strobe    (out_strobe),
    .out_move_code (out_move_code)
  );

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> ##LATENCY out_strobe)
    else $error("accepted particle gave no result at the expected cycle");

  a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(take, LATENCY))
    else $error("result word without a matching accepted particle");

endmodule

`default_nettype wire

[hdl/mchs_front.sv]
// ----------------------------------------------------------------------------
// mchs_front: configuration registers and item intake
// Registers each particle, forms the outgoing face fluxes and the partial
// products of the draw key, then builds the key and cumulative fluxes
// that are written into the item queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mchs_front
  import mchs_pkg::*;
#(
  parameter int FLUX_WIDTH = FLUX_WIDTH_DEF,
  parameter int CUM_WIDTH  = FLUX_WIDTH + 3,
  parameter int ENTRY_W    = 64 + FLUX_WIDTH + 6 * CUM_WIDTH + 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [63:0]           cfg_data,
  input  wire logic                  take,
  input  wire logic [30:0]           in_particle_tag,
  input  wire logic                  in_active,
  input  wire logic [FLUX_WIDTH-1:0] in_cell_mass,
  input  wire logic [FLUX_WIDTH-1:0] in_flux_x1_low,
  input  wire logic [FLUX_WIDTH-1:0] in_flux_x1_high,
  input  wire logic [FLUX_WIDTH-1:0] in_flux_x2_low,
  input  wire logic [FLUX_WIDTH-1:0] in_flux_x2_high,
  input  wire logic [FLUX_WIDTH-1:0] in_flux_x3_low,
  input  wire logic [FLUX_WIDTH-1:0] in_flux_x3_high,
  output logic                       push,
  output logic [ENTRY_W-1:0]         push_data
);

  logic [63:0] seed_r;
  logic [30:0] step_cycle_r;
  logic [1:0]  dims_r;

  logic                       vld_r;
  logic [62:0]                tag_pp0_r;
  logic [31:0]                tag_pp1_r;
  logic [62:0]                cyc_pp0_r;
  logic [31:0]                cyc_pp1_r;
  logic [FLUX_WIDTH-1:0]      mass_r;
  logic                       no_move_r;
  logic [5:0][FLUX_WIDTH-1:0] outg_r;

  logic [5:0][FLUX_WIDTH-1:0] flux_in;
  logic [5:0][FLUX_WIDTH-1:0] outg_nxt;
  logic                       ax2_on;
  logic                       ax3_on;
  logic [5:0][CUM_WIDTH-1:0]  cum;
  logic [63:0]                key;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r       <= '0;
      step_cycle_r <= '0;
      dims_r       <= 2'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RANDOM_SEED: seed_r       <= cfg_data;
        CFG_STEP_CYCLE:  step_cycle_r <= cfg_data[30:0];
        CFG_DIMENSIONS:  dims_r       <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // A dimensions value of zero behaves as one: the x1 axis is always on.
  assign ax2_on = (dims_r == 2'd2) || (dims_r == 2'd3);
  assign ax3_on = (dims_r == 2'd3);

  assign flux_in[0] = in_flux_x1_low;
  assign flux_in[1] = in_flux_x1_high;
  assign flux_in[2] = in_flux_x2_low;
  assign flux_in[3] = in_flux_x2_high;
  assign flux_in[4] = in_flux_x3_low;
  assign flux_in[5] = in_flux_x3_high;

  // Low faces lose mass through a negative flux, high faces through a
  // positive one.
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      if (i % 2 == 0) begin
        outg_nxt[i] = flux_in[i][FLUX_WIDTH-1] ? (~flux_in[i] + 1'b1) : '0;
      end else begin
        outg_nxt[i] = flux_in[i][FLUX_WIDTH-1] ? '0 : flux_in[i];
      end
    end
    if (!ax2_on) begin
      outg_nxt[2] = '0;
      outg_nxt[3] = '0;
    end
    if (!ax3_on) begin
      outg_nxt[4] = '0;
      outg_nxt[5] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    tag_pp0_r <= in_particle_tag * TAG_MULT[31:0];
    tag_pp1_r <= in_particle_tag * TAG_MULT[63:32];
    cyc_pp0_r <= step_cycle_r * GOLDEN_GAMMA[31:0];
    cyc_pp1_r <= step_cycle_r * GOLDEN_GAMMA[63:32];
    mass_r    <= in_cell_mass;
    no_move_r <= !in_active || (in_cell_mass == '0);
    outg_r    <= outg_nxt;
  end

  always_comb begin
    key = seed_r
        ^ (64'(tag_pp0_r) + {tag_pp1_r, 32'd0})
        ^ (64'(cyc_pp0_r) + {cyc_pp1_r, 32'd0})
        ^ DRAW_TERM;
    cum[0] = CUM_WIDTH'(outg_r[0]);
    for (int i = 1; i < 6; i++) begin
      cum[i] = cum[i-1] + CUM_WIDTH'(outg_r[i]);
    end
  end

  assign push      = vld_r;
  assign push_data = {key, mass_r, cum, no_move_r};

endmodule

`default_nettype wire

[hdl/mchs_queue.sv]
// ----------------------------------------------------------------------------
// mchs_queue: short item queue between front end and back end
// A small circular buffer of prepared items. It reports empty and a
// nearly-full level that leaves room for the item still in the front end.
// ----------------------------------------------------------------------------
`default_nettype none

module mchs_queue
  import mchs_pkg::*;
#(
  parameter int WIDTH = 64,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output q_status_t             status
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_pop;

  assign do_pop = pop && (count_r != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  assign pop_data           = mem[rd_ptr_r];
  assign status.empty       = (count_r == '0);
  assign status.nearly_full = (count_r >= CNT_W'(DEPTH - 1));

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !do_pop && (count_r == CNT_W'(DEPTH))))
    else $error("item queue written while full");

endmodule

`default_nettype wire

[hdl/mchs_back.sv]
// ----------------------------------------------------------------------------
// mchs_back: draw and face selection pipeline
// Mixes the key into a uniform draw, scales it by the cell mass and picks
// the first face whose cumulative outgoing flux lies above the draw, else no move.
// ----------------------------------------------------------------------------
`default_nettype none

module mchs_back
  import mchs_pkg::*;
#(
  parameter int DRAW_BITS  = DRAW_BITS_DEF,
  parameter int FLUX_WIDTH = FLUX_WIDTH_DEF,
  parameter int CUM_WIDTH  = FLUX_WIDTH + 3,
  parameter int ENTRY_W    = 64 + FLUX_WIDTH + 6 * CUM_WIDTH + 1
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               item_valid,
  input  wire logic [ENTRY_W-1:0] item_data,
  output logic                    item_pop,
  output logic                    out_strobe,
  output logic [2:0]              out_move_code
);

  localparam int SIDE_W = FLUX_WIDTH + 6 * CUM_WIDTH + 1;
  localparam int LHS_W  = 64 + FLUX_WIDTH;

  logic [5:0]             vld_r;
  logic [5:0][SIDE_W-1:0] side_r;
  logic [63:0]            x_r;
  logic [63:0]            m1_pp0_r;
  logic [31:0]            m1_pp1_r;
  logic [63:0]            z_r;
  logic [63:0]            m2_pp0_r;
  logic [31:0]            m2_pp1_r;
  logic [63:0]            u_r;
  logic [31+FLUX_WIDTH:0] plo_r;
  logic [31+FLUX_WIDTH:0] phi_r;
  logic                   out_strobe_r;
  move_code_t             out_code_r;

  logic [63:0]               key;
  logic [63:0]               v0;
  logic [63:0]               y;
  logic [63:0]               w;
  logic [63:0]               m;
  logic [FLUX_WIDTH-1:0]     s4_mass;
  logic [5:0][CUM_WIDTH-1:0] s5_cum;
  logic                      s5_no_move;
  logic [LHS_W-1:0]          lhs;
  logic [LHS_W-1:0]          q;
  move_code_t                code_nxt;
  logic                      found;

  assign item_pop = item_valid;
  assign key      = item_data[ENTRY_W-1 -: 64];
  assign v0       = key + GOLDEN_GAMMA;
  assign y        = m1_pp0_r + {m1_pp1_r, 32'd0};
  assign w        = m2_pp0_r + {m2_pp1_r, 32'd0};
  assign m        = w ^ (w >> 31);

  assign s4_mass    = side_r[4][SIDE_W-1 -: FLUX_WIDTH];
  assign s5_cum     = side_r[5][6*CUM_WIDTH:1];
  assign s5_no_move = side_r[5][0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      vld_r        <= {vld_r[4:0], item_valid};
      out_strobe_r <= vld_r[5];
    end
  end

  // Each 64-bit product modulo 2^64 is split into one full low product and
  // two 32-bit cross terms, summed in the following stage.
  always_ff @(posedge clk) begin
    side_r[0] <= item_data[SIDE_W-1:0];
    for (int i = 1; i < 6; i++) begin
      side_r[i] <= side_r[i-1];
    end
    x_r      <= v0 ^ (v0 >> 30);
    m1_pp0_r <= x_r[31:0] * MIX_C1[31:0];
    m1_pp1_r <= x_r[31:0] * MIX_C1[63:32] + x_r[63:32] * MIX_C1[31:0];
    z_r      <= y ^ (y >> 27);
    m2_pp0_r <= z_r[31:0] * MIX_C2[31:0];
    m2_pp1_r <= z_r[31:0] * MIX_C2[63:32] + z_r[63:32] * MIX_C2[31:0];
    u_r      <= m >> (64 - DRAW_BITS);
    plo_r    <= u_r[31:0] * s4_mass;
    phi_r    <= u_r[63:32] * s4_mass;
    out_code_r <= code_nxt;
  end

  // The test draw * mass < cum * 2^DRAW_BITS reduces to comparing the
  // integer part of the scaled draw with the cumulative flux, since the
  // right side has no fractional bits.
  always_comb begin
    lhs      = LHS_W'(plo_r) + (LHS_W'(phi_r) << 32);
    q        = lhs >> DRAW_BITS;
    code_nxt = MOVE_NONE;
    found    = 1'b0;
    for (int i = 0; i < 6; i++) begin
      if (!found && (q < LHS_W'(s5_cum[i]))) begin
        code_nxt = move_code_t'(3'(i + 1));
        found    = 1'b1;
      end
    end
    if (s5_no_move) begin
      code_nxt = MOVE_NONE;
    end
  end

  assign out_strobe    = out_strobe_r;
  assign out_move_code = out_code_r;

endmodule

`default_nettype wire
